// ===== hw/rtl/template_tag_tokenizer_defines.svh =====
// Assertion macros for the template tag tokenizer.
// Needs clk and rst_n in the scope where the macros are used.
`ifndef TEMPLATE_TAG_TOKENIZER_DEFINES_SVH
`define TEMPLATE_TAG_TOKENIZER_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define TTT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define TTT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TTT_ASSERT_IMP(lbl, ante, cons)
`define TTT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/ttt_pkg.sv =====
// Shared types, character codes and the sigil decoder for the tokenizer.
// No dependencies.
`default_nettype none
package ttt_pkg;

    typedef enum logic [1:0] {
        MODE_TEXT,
        MODE_AFTER_CLOSE,
        MODE_TYPE,
        MODE_BODY
    } mode_t;

    typedef enum logic [2:0] {
        KIND_TEXT,
        KIND_OPEN,
        KIND_BODY,
        KIND_CLOSE,
        KIND_END_OK,
        KIND_UNMATCHED
    } kind_t;

    typedef enum logic [3:0] {
        TAG_HTML,
        TAG_RAW,
        TAG_URL,
        TAG_SPACE,
        TAG_ASSERT,
        TAG_NOT,
        TAG_END,
        TAG_FOREACH,
        TAG_FORELSE,
        TAG_EXEC,
        TAG_INCLUDE,
        TAG_SUB
    } tag_t;

    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_QUEST   = 8'h3F;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_TILDE   = 8'h7E;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_GT      = 8'h3E;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        tag_t       tag;
        logic       last;
    } token_t;

    typedef struct packed {
        logic   hit;
        tag_t   tag;
    } sigil_t;

    // Step result: up to two tokens plus the next scanner state.
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
        mode_t      mode;
        logic       pending;
    } step_t;

    function automatic sigil_t decode_sigil(input logic [7:0] b);
        sigil_t s;
        s.hit = 1'b1;
        case (b)
            CH_AMP:     s.tag = TAG_RAW;
            CH_PERCENT: s.tag = TAG_URL;
            CH_UNDER:   s.tag = TAG_SPACE;
            CH_QUEST:   s.tag = TAG_ASSERT;
            CH_CARET:   s.tag = TAG_NOT;
            CH_SLASH:   s.tag = TAG_END;
            CH_HASH:    s.tag = TAG_FOREACH;
            CH_TILDE:   s.tag = TAG_FORELSE;
            CH_BANG:    s.tag = TAG_EXEC;
            CH_LT:      s.tag = TAG_INCLUDE;
            CH_GT:      s.tag = TAG_SUB;
            default:
            begin
                s.hit = 1'b0;
                s.tag = TAG_HTML;
            end
        endcase
        return s;
    endfunction

    function automatic token_t make_token(input kind_t k, input logic [7:0] d, input tag_t t);
        token_t r;
        r.kind = k;
        r.data = d;
        r.tag  = t;
        r.last = 1'b0;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ttt_step.sv =====
// Combinational scanner step: one item and the current state in, up to
// two tokens and the next state out. Depends on ttt_pkg.
`default_nettype none
module ttt_step (
    input  wire logic          operation,
    input  wire logic [7:0]    in_byte,
    input  wire ttt_pkg::mode_t mode,
    input  wire logic          pending,
    output ttt_pkg::step_t     step
);
    import ttt_pkg::*;

    sigil_t sig;
    token_t t0;
    token_t t1;
    logic [1:0] cnt;
    mode_t mode_next;
    logic pend_next;

    assign sig = decode_sigil(in_byte);

    always_comb
    begin
        t0        = make_token(KIND_TEXT, 8'h00, TAG_HTML);
        t1        = make_token(KIND_TEXT, 8'h00, TAG_HTML);
        cnt       = 2'd0;
        mode_next = mode;
        pend_next = pending;
        if (operation)
        begin
            mode_next = MODE_TEXT;
            pend_next = 1'b0;
            if (mode == MODE_TEXT || mode == MODE_AFTER_CLOSE)
            begin
                if (pending)
                begin
                    t0  = make_token(KIND_TEXT, CH_LBRACE, TAG_HTML);
                    t1  = make_token(KIND_END_OK, 8'h00, TAG_HTML);
                    cnt = 2'd2;
                end
                else
                begin
                    t0  = make_token(KIND_END_OK, 8'h00, TAG_HTML);
                    cnt = 2'd1;
                end
            end
            else if (mode == MODE_BODY && pending)
            begin
                t0  = make_token(KIND_BODY, CH_RBRACE, TAG_HTML);
                t1  = make_token(KIND_UNMATCHED, 8'h00, TAG_HTML);
                cnt = 2'd2;
            end
            else
            begin
                t0  = make_token(KIND_UNMATCHED, 8'h00, TAG_HTML);
                cnt = 2'd1;
            end
        end
        else
        begin
            case (mode)
                MODE_AFTER_CLOSE, MODE_TEXT:
                begin
                    mode_next = MODE_TEXT;
                    pend_next = 1'b0;
                    if (mode == MODE_AFTER_CLOSE && in_byte == CH_NEWLINE)
                    begin
                        // drop the newline right after a close
                        cnt = 2'd0;
                    end
                    else if (mode == MODE_TEXT && pending)
                    begin
                        if (in_byte == CH_LBRACE)
                        begin
                            mode_next = MODE_TYPE;
                        end
                        else
                        begin
                            t0  = make_token(KIND_TEXT, CH_LBRACE, TAG_HTML);
                            t1  = make_token(KIND_TEXT, in_byte, TAG_HTML);
                            cnt = 2'd2;
                        end
                    end
                    else if (in_byte == CH_LBRACE)
                    begin
                        pend_next = 1'b1;
                    end
                    else
                    begin
                        t0  = make_token(KIND_TEXT, in_byte, TAG_HTML);
                        cnt = 2'd1;
                    end
                end
                MODE_TYPE:
                begin
                    mode_next = MODE_BODY;
                    pend_next = 1'b0;
                    cnt       = 2'd1;
                    if (sig.hit)
                    begin
                        t0 = make_token(KIND_OPEN, 8'h00, sig.tag);
                    end
                    else
                    begin
                        t0 = make_token(KIND_OPEN, 8'h00, TAG_HTML);
                        if (in_byte == CH_RBRACE)
                        begin
                            pend_next = 1'b1;
                        end
                        else
                        begin
                            t1  = make_token(KIND_BODY, in_byte, TAG_HTML);
                            cnt = 2'd2;
                        end
                    end
                end
                default:
                begin
                    if (pending)
                    begin
                        pend_next = 1'b0;
                        if (in_byte == CH_RBRACE)
                        begin
                            mode_next = MODE_AFTER_CLOSE;
                            t0        = make_token(KIND_CLOSE, 8'h00, TAG_HTML);
                            cnt       = 2'd1;
                        end
                        else
                        begin
                            t0  = make_token(KIND_BODY, CH_RBRACE, TAG_HTML);
                            t1  = make_token(KIND_BODY, in_byte, TAG_HTML);
                            cnt = 2'd2;
                        end
                    end
                    else if (in_byte == CH_RBRACE)
                    begin
                        pend_next = 1'b1;
                    end
                    else
                    begin
                        t0  = make_token(KIND_BODY, in_byte, TAG_HTML);
                        cnt = 2'd1;
                    end
                end
            endcase
        end
        t0.last = (cnt == 2'd1);
        t1.last = 1'b1;
    end

    assign step.count   = cnt;
    assign step.first   = t0;
    assign step.second  = t1;
    assign step.mode    = mode_next;
    assign step.pending = pend_next;

endmodule
`default_nettype wire

// ===== hw/rtl/template_tag_tokenizer.sv =====
// Template tag tokenizer: input register, one step of scanner logic, and a
// two-slot result buffer that hands out one token per cycle while out_stall
// is low. Throughput while out_stall is low: 1 item per cycle for items of
// up to one token; an item with two tokens holds off the next item until
// its first token has left; the one-token-per-cycle output sets this.
// Reset: scanner in text mode, nothing pending, buffers empty.
`default_nettype none
`include "template_tag_tokenizer_defines.svh"
module template_tag_tokenizer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        operation,
    input  wire logic [7:0]  in_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       token_kind,
    output logic [7:0]       out_byte,
    output logic [3:0]       tag_type,
    output logic             last_of_run
);
    import ttt_pkg::*;

    logic       item_valid_reg;
    logic       item_op_reg;
    logic [7:0] item_byte_reg;

    mode_t      mode_reg;
    logic       pending_reg;

    token_t     head_reg;
    token_t     tail_reg;
    logic [1:0] count_reg;

    step_t      step;
    logic       pop;
    logic       process;

    ttt_step u_step (
        .operation (item_op_reg),
        .in_byte   (item_byte_reg),
        .mode      (mode_reg),
        .pending   (pending_reg),
        .step      (step)
    );

    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && !out_stall;
    // run the step once the buffer is empty or drains this cycle
    assign process   = item_valid_reg &&
                       (count_reg == 2'd0 || (count_reg == 2'd1 && pop));
    assign in_stall  = item_valid_reg && !process;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            item_op_reg   <= operation;
            item_byte_reg <= in_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_TEXT;
            pending_reg <= 1'b0;
            count_reg   <= 2'd0;
        end
        else if (process)
        begin
            mode_reg    <= step.mode;
            pending_reg <= step.pending;
            count_reg   <= step.count;
        end
        else if (pop)
        begin
            count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            head_reg <= step.first;
            tail_reg <= step.second;
        end
        else if (pop)
        begin
            head_reg <= tail_reg;
        end
    end

    assign token_kind  = head_reg.kind;
    assign out_byte    = head_reg.data;
    assign tag_type    = head_reg.tag;
    assign last_of_run = head_reg.last;

    `TTT_ASSERT_IMP(a_count_range, 1'b1, count_reg != 2'd3)
    `TTT_ASSERT_IMP(a_single_is_last, count_reg == 2'd1, head_reg.last)
    `TTT_ASSERT_IMP(a_pending_mode, pending_reg, mode_reg == MODE_TEXT || mode_reg == MODE_BODY)
    `TTT_ASSERT_NXT(a_pair_drains, count_reg == 2'd2 && pop, count_reg == 2'd1)

endmodule
`default_nettype wire

// ===== verif/template_tag_tokenizer_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for template_tag_tokenizer: a directed table, then random
// template documents; tokens are checked against table rows or a local scanner model.
// Depends on ttt_pkg and the tokenizer RTL.
module template_tag_tokenizer_test;
    import ttt_pkg::*;

    localparam logic OP_DATA      = 1'b0;
    localparam logic OP_END       = 1'b1;
    localparam int   ITEM_TARGET  = 1450;
    localparam int   HOLD_CYCLES  = 300;
    localparam int   QUIET_LIMIT  = 3000;
    localparam int   DRAIN_CYCLES = 10;
    localparam int   REPORT_LIMIT = 10;

    typedef struct packed {
        logic       op;
        logic [7:0] b;
        logic       known;
        logic [1:0] n;
        token_t     t0;
        token_t     t1;
    } stim_row_t;

    localparam token_t NO_TOK = '0;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       operation;
    logic [7:0] in_byte;
    logic       out_valid;
    logic       out_stall;
    logic [2:0] token_kind;
    logic [7:0] out_byte;
    logic [3:0] tag_type;
    logic       last_of_run;

    // scanner state mirrored from the block
    mode_t      scan_state;
    logic       brace_held;
    token_t     step_tokens[$];
    token_t     tokens_due[$];

    int         items_sent = 0;
    int         ends_sent = 0;
    int         tokens_checked = 0;
    int         mismatches = 0;
    int         burst_left = 0;
    logic       hold_wanted = 1'b0;
    logic       hold_served;

    template_tag_tokenizer DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .token_kind  (token_kind),
        .out_byte    (out_byte),
        .tag_type    (tag_type),
        .last_of_run (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic token_t tok(input kind_t k, input logic [7:0] d, input tag_t t,
                                   input logic l);
        token_t r;
        r.kind = k;
        r.data = d;
        r.tag  = t;
        r.last = l;
        return r;
    endfunction

    function automatic stim_row_t row_scan(input logic op, input logic [7:0] b);
        stim_row_t r;
        r = '0;
        r.op = op;
        r.b  = b;
        return r;
    endfunction

    function automatic stim_row_t row_known(input logic op, input logic [7:0] b,
                                            input logic [1:0] n, input token_t t0,
                                            input token_t t1);
        stim_row_t r;
        r.op    = op;
        r.b     = b;
        r.known = 1'b1;
        r.n     = n;
        r.t0    = t0;
        r.t1    = t1;
        return r;
    endfunction

    function automatic logic [7:0] sigil_char(input tag_t t);
        case (t)
            TAG_RAW:     return CH_AMP;
            TAG_URL:     return CH_PERCENT;
            TAG_SPACE:   return CH_UNDER;
            TAG_ASSERT:  return CH_QUEST;
            TAG_NOT:     return CH_CARET;
            TAG_END:     return CH_SLASH;
            TAG_FOREACH: return CH_HASH;
            TAG_FORELSE: return CH_TILDE;
            TAG_EXEC:    return CH_BANG;
            TAG_INCLUDE: return CH_LT;
            default:     return CH_GT;
        endcase
    endfunction

    function automatic void add_token(input kind_t k, input logic [7:0] d, input tag_t t);
        step_tokens.push_back(tok(k, d, t, 1'b0));
    endfunction

    function automatic void scan_text(input logic [7:0] b);
        if (brace_held)
        begin
            brace_held = 1'b0;
            if (b == CH_LBRACE)
                scan_state = MODE_TYPE;
            else
            begin
                add_token(KIND_TEXT, CH_LBRACE, TAG_HTML);
                add_token(KIND_TEXT, b, TAG_HTML);
            end
        end
        else if (b == CH_LBRACE)
            brace_held = 1'b1;
        else
            add_token(KIND_TEXT, b, TAG_HTML);
    endfunction

    function automatic void scan_body(input logic [7:0] b);
        if (brace_held)
        begin
            brace_held = 1'b0;
            if (b == CH_RBRACE)
            begin
                scan_state = MODE_AFTER_CLOSE;
                add_token(KIND_CLOSE, 8'h00, TAG_HTML);
            end
            else
            begin
                add_token(KIND_BODY, CH_RBRACE, TAG_HTML);
                add_token(KIND_BODY, b, TAG_HTML);
            end
        end
        else if (b == CH_RBRACE)
            brace_held = 1'b1;
        else
            add_token(KIND_BODY, b, TAG_HTML);
    endfunction

    // Advance the scanner by one input and leave its tokens in step_tokens.
    function automatic void scan_item(input logic op, input logic [7:0] b);
        tag_t   found;
        logic   hit;
        token_t tail;
        step_tokens.delete();
        if (op == OP_END)
        begin
            if (scan_state == MODE_TEXT || scan_state == MODE_AFTER_CLOSE)
            begin
                if (brace_held)
                    add_token(KIND_TEXT, CH_LBRACE, TAG_HTML);
                add_token(KIND_END_OK, 8'h00, TAG_HTML);
            end
            else
            begin
                if (scan_state == MODE_BODY && brace_held)
                    add_token(KIND_BODY, CH_RBRACE, TAG_HTML);
                add_token(KIND_UNMATCHED, 8'h00, TAG_HTML);
            end
            scan_state = MODE_TEXT;
            brace_held = 1'b0;
        end
        else
        begin
            case (scan_state)
                MODE_AFTER_CLOSE:
                begin
                    scan_state = MODE_TEXT;
                    brace_held = 1'b0;
                    if (b != CH_NEWLINE)
                        scan_text(b);
                end
                MODE_TEXT:
                    scan_text(b);
                MODE_TYPE:
                begin
                    hit   = 1'b0;
                    found = TAG_HTML;
                    for (int i = TAG_RAW; i <= TAG_SUB; i++)
                    begin
                        if (b == sigil_char(tag_t'(i)))
                        begin
                            hit   = 1'b1;
                            found = tag_t'(i);
                        end
                    end
                    scan_state = MODE_BODY;
                    brace_held = 1'b0;
                    add_token(KIND_OPEN, 8'h00, found);
                    if (!hit)
                        scan_body(b);
                end
                default:
                    scan_body(b);
            endcase
        end
        if (step_tokens.size() > 0)
        begin
            tail = step_tokens.pop_back();
            tail.last = 1'b1;
            step_tokens.push_back(tail);
        end
    endfunction

    function automatic void flag_error(input string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("ERROR at %0t: %s", $time, what);
    endfunction

    // Offer one item, hold it until the transfer, then maybe open a gap.
    task automatic transfer_item(input stim_row_t r);
        int gap;
        in_valid  = 1'b1;
        operation = r.op;
        in_byte   = r.b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        scan_item(r.op, r.b);
        if (r.known)
        begin
            if (r.n > 2'd0)
                tokens_due.push_back(r.t0);
            if (r.n > 2'd1)
                tokens_due.push_back(r.t1);
        end
        else
        begin
            foreach (step_tokens[i])
                tokens_due.push_back(step_tokens[i]);
        end
        items_sent++;
        if (r.op == OP_END)
            ends_sent++;
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 60);
            gap = $urandom_range(1, 9);
            in_valid = 1'b0;
            repeat (gap)
                @(negedge clk);
        end
    endtask

    task automatic send_tag(input logic close_it);
        int         body_len;
        logic [7:0] c;
        transfer_item(row_scan(OP_DATA, CH_LBRACE));
        transfer_item(row_scan(OP_DATA, CH_LBRACE));
        if ($urandom_range(0, 9) < 7)
            c = sigil_char(tag_t'($urandom_range(TAG_RAW, TAG_SUB)));
        else
            c = 8'($urandom_range(0, 255));
        transfer_item(row_scan(OP_DATA, c));
        body_len = $urandom_range(0, 8);
        repeat (body_len)
        begin
            // a lone close brace now and then
            if ($urandom_range(0, 7) == 0)
                transfer_item(row_scan(OP_DATA, CH_RBRACE));
            transfer_item(row_scan(OP_DATA, 8'($urandom_range(0, 255))));
        end
        if (close_it)
        begin
            transfer_item(row_scan(OP_DATA, CH_RBRACE));
            transfer_item(row_scan(OP_DATA, CH_RBRACE));
            if ($urandom_range(0, 2) == 0)
                transfer_item(row_scan(OP_DATA, CH_NEWLINE));
        end
    endtask

    task automatic send_document();
        int         pieces;
        int         style;
        int         run;
        logic [7:0] c;
        pieces = $urandom_range(1, 6);
        repeat (pieces)
        begin
            style = $urandom_range(0, 19);
            if (style < 10)
            begin
                run = $urandom_range(1, 12);
                repeat (run)
                begin
                    if ($urandom_range(0, 9) == 0)
                        transfer_item(row_scan(OP_DATA, CH_LBRACE));
                    transfer_item(row_scan(OP_DATA, 8'($urandom_range(0, 255))));
                end
            end
            else if (style < 17)
                send_tag(1'b1);
            else
            begin
                // noise weighted toward braces and newlines
                run = $urandom_range(1, 10);
                repeat (run)
                begin
                    case ($urandom_range(0, 3))
                        0:       c = CH_LBRACE;
                        1:       c = CH_RBRACE;
                        2:       c = CH_NEWLINE;
                        default: c = 8'($urandom_range(0, 255));
                    endcase
                    transfer_item(row_scan(OP_DATA, c));
                end
            end
        end
        style = $urandom_range(0, 9);
        if (style == 0)
        begin
            // leave a tag open before the end marker
            if ($urandom_range(0, 1) == 0)
            begin
                transfer_item(row_scan(OP_DATA, CH_LBRACE));
                transfer_item(row_scan(OP_DATA, CH_LBRACE));
            end
            else
            begin
                send_tag(1'b0);
                if ($urandom_range(0, 1) == 0)
                    transfer_item(row_scan(OP_DATA, CH_RBRACE));
            end
            transfer_item(row_scan(OP_END, 8'($urandom_range(0, 255))));
        end
        else if (style < 9)
            transfer_item(row_scan(OP_END, 8'($urandom_range(0, 255))));
    endtask

    always @(posedge clk)
    begin : result_check
        token_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (tokens_due.size() == 0)
                flag_error($sformatf("unexpected token kind %0d byte %02h tag %0d last %0b",
                                     token_kind, out_byte, tag_type, last_of_run));
            else
            begin
                want = tokens_due.pop_front();
                tokens_checked++;
                if (token_kind !== want.kind || out_byte !== want.data ||
                    tag_type !== want.tag || last_of_run !== want.last)
                    flag_error($sformatf({"expected kind %0d byte %02h tag %0d last %0b,",
                                          " got kind %0d byte %02h tag %0d last %0b"},
                                         want.kind, want.data, want.tag, want.last,
                                         token_kind, out_byte, tag_type, last_of_run));
            end
        end
    end

    // Receiver: stall styles in spans, plus one long hold-off when asked.
    initial
    begin
        int style;
        int span;
        out_stall   = 1'b0;
        hold_served = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_wanted && !hold_served)
            begin
                hold_served = 1'b1;
                repeat (HOLD_CYCLES)
                begin
                    @(negedge clk);
                    out_stall = 1'b1;
                end
            end
            else
            begin
                style = $urandom_range(0, 2);
                span  = $urandom_range(20, 200);
                for (int i = 0; i < span && !(hold_wanted && !hold_served); i++)
                begin
                    @(negedge clk);
                    case (style)
                        0:       out_stall = 1'b0;
                        1:       out_stall = ($urandom_range(0, 99) < 40);
                        default: out_stall = ((i % 5) >= 3);
                    endcase
                end
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        stim_row_t opening[$];
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        operation  = OP_DATA;
        in_byte    = 8'h00;
        scan_state = MODE_TEXT;
        brace_held = 1'b0;

        opening.push_back(row_known(OP_DATA, 8'h00, 2'd1,
                                    tok(KIND_TEXT, 8'h00, TAG_HTML, 1'b1), NO_TOK));
        opening.push_back(row_known(OP_DATA, 8'hFF, 2'd1,
                                    tok(KIND_TEXT, 8'hFF, TAG_HTML, 1'b1), NO_TOK));
        opening.push_back(row_known(OP_DATA, CH_LBRACE, 2'd0, NO_TOK, NO_TOK));
        // end with an open brace held: flush it as text, then end ok
        opening.push_back(row_known(OP_END, 8'hFF, 2'd2,
                                    tok(KIND_TEXT, CH_LBRACE, TAG_HTML, 1'b0),
                                    tok(KIND_END_OK, 8'h00, TAG_HTML, 1'b1)));
        // end while the type byte is still awaited
        opening.push_back(row_scan(OP_DATA, CH_LBRACE));
        opening.push_back(row_scan(OP_DATA, CH_LBRACE));
        opening.push_back(row_known(OP_END, 8'h00, 2'd1,
                                    tok(KIND_UNMATCHED, 8'h00, TAG_HTML, 1'b1), NO_TOK));
        // close brace as type byte, single close brace in the body, end inside the tag
        opening.push_back(row_scan(OP_DATA, CH_LBRACE));
        opening.push_back(row_scan(OP_DATA, CH_LBRACE));
        opening.push_back(row_scan(OP_DATA, CH_RBRACE));
        opening.push_back(row_scan(OP_DATA, 8'h7A));
        opening.push_back(row_scan(OP_DATA, CH_RBRACE));
        opening.push_back(row_known(OP_END, 8'h5A, 2'd2,
                                    tok(KIND_BODY, CH_RBRACE, TAG_HTML, 1'b0),
                                    tok(KIND_UNMATCHED, 8'h00, TAG_HTML, 1'b1)));
        // single open brace in text
        opening.push_back(row_scan(OP_DATA, CH_LBRACE));
        opening.push_back(row_scan(OP_DATA, 8'h78));
        // sigil tag, closed, newline dropped
        opening.push_back(row_scan(OP_DATA, CH_LBRACE));
        opening.push_back(row_scan(OP_DATA, CH_LBRACE));
        opening.push_back(row_scan(OP_DATA, CH_HASH));
        opening.push_back(row_scan(OP_DATA, CH_RBRACE));
        opening.push_back(row_scan(OP_DATA, CH_RBRACE));
        opening.push_back(row_scan(OP_DATA, CH_NEWLINE));
        // third open brace becomes the first body byte; end right after the close
        opening.push_back(row_scan(OP_DATA, CH_LBRACE));
        opening.push_back(row_scan(OP_DATA, CH_LBRACE));
        opening.push_back(row_scan(OP_DATA, CH_LBRACE));
        opening.push_back(row_scan(OP_DATA, CH_RBRACE));
        opening.push_back(row_scan(OP_DATA, CH_RBRACE));
        opening.push_back(row_known(OP_END, 8'hA5, 2'd1,
                                    tok(KIND_END_OK, 8'h00, TAG_HTML, 1'b1), NO_TOK));

        repeat (8)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (opening[i])
            transfer_item(opening[i]);

        hold_wanted = 1'b1;
        while (items_sent < ITEM_TARGET)
            send_document();
        in_valid = 1'b0;

        while (tokens_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Covered %0d inputs (%0d end markers) and %0d tokens; text, all sigil tags,",
                 items_sent, ends_sent, tokens_checked);
        $display("stray braces, open tags at end and one %0d-cycle output hold; %0d errors.",
                 HOLD_CYCLES, mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
